// ===== rtl/core/rre_pkg.sv =====
// Shared constants, codes and types of the rectangle raster engine.
package rre_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int ADDR_W    = 2 * SIDE_W;
  localparam int CANVAS_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int DIM_W     = SIDE_W + 1;
  localparam int CHAR_W    = 8;
  localparam int FIX_W     = 20;
  localparam int FRAC_W    = 8;
  localparam int BOUND_W   = FIX_W + 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [BOUND_W-1:0] FIX_ONE = BOUND_W'(1 << FRAC_W);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_CHAR = 2'd2;

  localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h72;
  localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h52;
  localparam logic [CHAR_W-1:0] BG_RESET      = 8'd32;
  localparam logic [DIM_W-1:0]  DIM_RESET     = DIM_W'(1);

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [FIX_W-1:0] rect_left;
    logic signed [FIX_W-1:0] rect_top;
    logic signed [FIX_W-1:0] rect_width;
    logic signed [FIX_W-1:0] rect_height;
    logic [CHAR_W-1:0]       shape_char;
    logic [CHAR_W-1:0]       paint_char;
    logic [SIDE_W-1:0]       read_col;
    logic [SIDE_W-1:0]       read_row;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_char;
    logic              rejected;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       reject;
    logic       walk_last;
    logic       out_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/rre_req_if.sv =====
// Request channel carrying clear, draw and read items.
interface rre_req_if;
  logic          valid;
  logic          ready;
  rre_pkg::req_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/core/rre_rsp_if.sv =====
// Response channel carrying one result per request.
interface rre_rsp_if;
  logic          valid;
  logic          ready;
  rre_pkg::rsp_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/core/rre_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module rre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rre_ctrl.sv =====
// Controller state machine sequencing request intake, the pixel walk and the result.
module rre_ctrl import rre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    req_ready_o = (state_q == ST_IDLE) && !status_i.out_busy;
    cmd_o.load  = req_valid_i && req_ready_o;
    cmd_o.walk  = (state_q == ST_WALK);
    cmd_o.push  = (state_q == ST_RESULT);

    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          case (status_i.kind)
            KIND_CLEAR: state_d = ST_WALK;
            KIND_DRAW:  state_d = status_i.reject ? ST_RESULT : ST_WALK;
            default:    state_d = ST_RESULT;
          endcase
        end
      end
      ST_WALK: begin
        if (status_i.walk_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/rre_datapath.sv =====
// Datapath: configuration registers, rectangle bounds, pixel walk, canvas RAM and result register.
module rre_datapath import rre_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  req_t                 req_item_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output rsp_t                 rsp_item_o
);

  logic [DIM_W-1:0]  width_q, height_q;
  logic [CHAR_W-1:0] bg_q;

  logic [SIDE_W-1:0] cols_last, rows_last;
  logic [DIM_W-1:0]  width_m1, height_m1;
  logic              bad_shape, reject;

  logic signed [BOUND_W-1:0] left_ext, top_ext, right_ext, bottom_ext;

  logic [1:0]                kind_q;
  logic                      rej_q, filled_q, rd_hit_q;
  logic [CHAR_W-1:0]         paint_q;
  logic [SIDE_W-1:0]         cols_last_q, rows_last_q;
  logic signed [BOUND_W-1:0] left_q, right_q, top_q, bottom_q;
  logic signed [BOUND_W-1:0] left_in_q, right_in_q, top_in_q, bottom_in_q;

  logic [SIDE_W-1:0]         walk_col_q, walk_row_q;
  logic signed [BOUND_W-1:0] px, py;
  logic                      in_rect, border, ram_we;
  logic [CHAR_W-1:0]         ram_wdata, ram_rdata;

  logic rsp_valid_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      bg_q     <= BG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CANVAS_WIDTH:    width_q  <= cfg_data_i;
        CFG_CANVAS_HEIGHT:   height_q <= cfg_data_i;
        CFG_BACKGROUND_CHAR: bg_q     <= cfg_data_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one column or row; anything above the canvas side is clamped.
  always_comb begin
    width_m1  = width_q - DIM_W'(1);
    height_m1 = height_q - DIM_W'(1);
    if (width_q == '0) begin
      cols_last = '0;
    end else if (width_q > DIM_W'(MAX_SIDE)) begin
      cols_last = SIDE_W'(MAX_SIDE - 1);
    end else begin
      cols_last = width_m1[SIDE_W-1:0];
    end
    if (height_q == '0) begin
      rows_last = '0;
    end else if (height_q > DIM_W'(MAX_SIDE)) begin
      rows_last = SIDE_W'(MAX_SIDE - 1);
    end else begin
      rows_last = height_m1[SIDE_W-1:0];
    end
  end

  always_comb begin
    bad_shape = (req_item_i.shape_char != SHAPE_OUTLINE) &&
                (req_item_i.shape_char != SHAPE_FILLED);
    reject    = (req_item_i.kind == KIND_DRAW) &&
                (req_item_i.rect_width[FIX_W-1] || req_item_i.rect_height[FIX_W-1] ||
                 bad_shape);
    left_ext   = BOUND_W'(req_item_i.rect_left);
    top_ext    = BOUND_W'(req_item_i.rect_top);
    right_ext  = left_ext + BOUND_W'(req_item_i.rect_width);
    bottom_ext = top_ext + BOUND_W'(req_item_i.rect_height);
  end

  // Bounds are stored with the one-pixel border band already applied, so each
  // pixel of the walk needs only compares.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= req_item_i.kind;
      rej_q       <= reject;
      filled_q    <= (req_item_i.shape_char == SHAPE_FILLED);
      paint_q     <= req_item_i.paint_char;
      cols_last_q <= cols_last;
      rows_last_q <= rows_last;
      rd_hit_q    <= (req_item_i.read_col <= cols_last) && (req_item_i.read_row <= rows_last);
      left_q      <= left_ext;
      right_q     <= right_ext;
      top_q       <= top_ext;
      bottom_q    <= bottom_ext;
      left_in_q   <= left_ext + FIX_ONE;
      right_in_q  <= right_ext - FIX_ONE;
      top_in_q    <= top_ext + FIX_ONE;
      bottom_in_q <= bottom_ext - FIX_ONE;
    end
  end

  always_comb begin
    px = signed'({{(BOUND_W - SIDE_W - FRAC_W){1'b0}}, walk_col_q, {FRAC_W{1'b0}}});
    py = signed'({{(BOUND_W - SIDE_W - FRAC_W){1'b0}}, walk_row_q, {FRAC_W{1'b0}}});
    in_rect = (px >= left_q) && (px <= right_q) && (py >= top_q) && (py <= bottom_q);
    border = (px < left_in_q) || (px > right_in_q) || (py < top_in_q) || (py > bottom_in_q);
    ram_we = cmd_i.walk &&
             ((kind_q == KIND_CLEAR) || (in_rect && (border || filled_q)));
    ram_wdata = (kind_q == KIND_CLEAR) ? bg_q : paint_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_col_q <= '0;
      walk_row_q <= '0;
    end else if (cmd_i.walk) begin
      if (walk_col_q == cols_last_q) begin
        walk_col_q <= '0;
        walk_row_q <= (walk_row_q == rows_last_q) ? '0 : walk_row_q + SIDE_W'(1);
      end else begin
        walk_col_q <= walk_col_q + SIDE_W'(1);
      end
    end
  end

  rre_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CANVAS_DEPTH)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({walk_row_q, walk_col_q}),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load && (req_item_i.kind == KIND_READ)),
    .raddr_i ({req_item_i.read_row, req_item_i.read_col}),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      rsp_q.pixel_char <= ((kind_q == KIND_READ) && rd_hit_q) ? ram_rdata : '0;
      rsp_q.rejected   <= rej_q;
    end
  end

  assign status_o.kind      = req_item_i.kind;
  assign status_o.reject    = reject;
  assign status_o.walk_last = (walk_col_q == cols_last_q) && (walk_row_q == rows_last_q);
  assign status_o.out_busy  = rsp_valid_q && !rsp_ready_i;
  assign rsp_valid_o        = rsp_valid_q;
  assign rsp_item_o         = rsp_q;

endmodule

// ===== rtl/core/rectangle_raster_engine.sv =====
// Rectangle raster engine: a character canvas with clear, rectangle draw and pixel read.
// A clear or an accepted draw request walks every pixel in use, one per cycle in row
// order through the single write port of the canvas RAM, and then issues its result.
// A read, a rejected draw or an unused kind goes straight to its result, the read
// taking its pixel from the registered RAM read. One request is handled at a time; the
// next one is taken while the previous result still waits in the output register, unless
// that register is full and not being drained. Pixels never written by a clear or a
// draw read back as undefined.
module rectangle_raster_engine import rre_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rre_req_if.sink               req_i,
  rre_rsp_if.source             rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rre_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_item_i  (req_i.item),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_item_o  (rsp_o.item)
  );

`ifndef SYNTHESIS
  // No request is taken while a result is stuck in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !(rsp_o.valid && !rsp_o.ready))
    else $error("request accepted while output register blocked");

  // The block never takes a request during a pixel walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk |-> !req_i.ready)
    else $error("request intake open during pixel walk");

  // A result is only written into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !rsp_o.valid)
    else $error("result overwrote a pending response");

  // Every result push is followed by a valid response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> rsp_o.valid)
    else $error("pushed result not presented");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the rectangle raster engine against a predicted canvas.
module tb_top;
  import rre_pkg::*;

  localparam int UNIT = 1 << FRAC_W;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] BAD_SHAPE = "Q";

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rre_req_if req_ch ();
  rre_rsp_if rsp_ch ();

  rectangle_raster_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  always #10 clk_i = ~clk_i;

  // Predicted canvas, with a flag for every pixel that has been written.
  logic [CHAR_W-1:0] canvas_px [CANVAS_DEPTH];
  bit canvas_set [CANVAS_DEPTH];
  logic [DIM_W-1:0] width_reg = DIM_RESET;
  logic [DIM_W-1:0] height_reg = DIM_RESET;
  logic [CHAR_W-1:0] bg_reg = BG_RESET;

  rsp_t pixel_answers [$];
  int mismatches = 0;
  int unsigned cycles_run = 0;
  bit idle_en = 1'b1;
  int hold_off_cycles = 0;

  function automatic int unsigned side_in_use(input logic [DIM_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > MAX_SIDE) return MAX_SIDE;
    return setting;
  endfunction

  task automatic rasterise_request(input req_t r, output rsp_t res);
    int unsigned cols, rows, addr;
    longint lft, tp, rgt, btm, px, py;
    bit in_rect, on_border;
    res = '0;
    cols = side_in_use(width_reg);
    rows = side_in_use(height_reg);
    case (r.kind)
      KIND_CLEAR: begin
        for (int y = 0; y < rows; y++)
          for (int x = 0; x < cols; x++) begin
            canvas_px[y * MAX_SIDE + x] = bg_reg;
            canvas_set[y * MAX_SIDE + x] = 1'b1;
          end
      end
      KIND_DRAW: begin
        if (r.rect_width < 0 || r.rect_height < 0 ||
            (r.shape_char != SHAPE_OUTLINE && r.shape_char != SHAPE_FILLED)) begin
          res.rejected = 1'b1;
        end else begin
          lft = longint'(r.rect_left);
          tp  = longint'(r.rect_top);
          rgt = lft + longint'(r.rect_width);
          btm = tp + longint'(r.rect_height);
          for (int y = 0; y < rows; y++) begin
            py = longint'(y) * UNIT;
            for (int x = 0; x < cols; x++) begin
              px = longint'(x) * UNIT;
              in_rect = px >= lft && px <= rgt && py >= tp && py <= btm;
              on_border = (px - lft) < UNIT || (rgt - px) < UNIT ||
                          (py - tp) < UNIT || (btm - py) < UNIT;
              if (in_rect && (on_border || r.shape_char == SHAPE_FILLED)) begin
                addr = y * MAX_SIDE + x;
                canvas_px[addr] = r.paint_char;
                canvas_set[addr] = 1'b1;
              end
            end
          end
        end
      end
      KIND_READ: begin
        if (r.read_col < cols && r.read_row < rows)
          res.pixel_char = canvas_px[r.read_row * MAX_SIDE + r.read_col];
      end
      default: ;
    endcase
  endtask

  function automatic req_t noise_item();
    req_t r;
    r.kind        = KIND_UNUSED;
    r.rect_left   = FIX_W'($urandom);
    r.rect_top    = FIX_W'($urandom);
    r.rect_width  = FIX_W'($urandom);
    r.rect_height = FIX_W'($urandom);
    r.shape_char  = CHAR_W'($urandom);
    r.paint_char  = CHAR_W'($urandom);
    r.read_col    = SIDE_W'($urandom);
    r.read_row    = SIDE_W'($urandom);
    return r;
  endfunction

  function automatic req_t clear_item();
    req_t r;
    r = noise_item();
    r.kind = KIND_CLEAR;
    return r;
  endfunction

  function automatic req_t read_item(input int col, input int row);
    req_t r;
    r = noise_item();
    r.kind = KIND_READ;
    r.read_col = SIDE_W'(col);
    r.read_row = SIDE_W'(row);
    return r;
  endfunction

  function automatic req_t draw_item(input int l, input int t, input int w, input int h,
                                     input logic [CHAR_W-1:0] shape,
                                     input logic [CHAR_W-1:0] paint);
    req_t r;
    r = noise_item();
    r.kind        = KIND_DRAW;
    r.rect_left   = FIX_W'(l);
    r.rect_top    = FIX_W'(t);
    r.rect_width  = FIX_W'(w);
    r.rect_height = FIX_W'(h);
    r.shape_char  = shape;
    r.paint_char  = paint;
    return r;
  endfunction

  // A draw that lands on and around a small canvas.
  function automatic req_t random_draw(input int cols, input int rows);
    int lft, tp, wd, ht;
    lft = int'($urandom_range(0, (cols + 4) * UNIT)) - 2 * UNIT;
    tp  = int'($urandom_range(0, (rows + 4) * UNIT)) - 2 * UNIT;
    wd  = int'($urandom_range(0, (cols + 2) * UNIT));
    ht  = int'($urandom_range(0, (rows + 2) * UNIT));
    if ($urandom_range(0, 2) == 0) begin
      // Whole-pixel corners put the edges exactly on pixel centres.
      lft = lft & ~(UNIT - 1);
      tp  = tp & ~(UNIT - 1);
      wd  = wd & ~(UNIT - 1);
      ht  = ht & ~(UNIT - 1);
    end
    return draw_item(lft, tp, wd, ht, $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE,
                     CHAR_W'($urandom));
  endfunction

  // Reads land on written pixels or outside the canvas; the small canvases used here
  // always leave column 255 outside.
  function automatic req_t random_read(input int cols, input int rows);
    int pick_col, pick_row;
    if ($urandom_range(0, 7) == 0) begin
      pick_col = $urandom_range(0, 255);
      pick_row = $urandom_range(0, 255);
    end else begin
      pick_col = $urandom_range(0, cols);
      pick_row = $urandom_range(0, rows);
    end
    if (pick_col < cols && pick_row < rows && !canvas_set[pick_row * MAX_SIDE + pick_col])
      pick_col = 255;
    return read_item(pick_col, pick_row);
  endfunction

  task automatic send_request(input req_t r);
    rsp_t want;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.item  <= r;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    rasterise_request(r, want);
    pixel_answers.push_back(want);
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (pixel_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned cols, input int unsigned rows,
                           input logic [CHAR_W-1:0] bg);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_CANVAS_WIDTH;
    cfg_data_i  <= CFG_DATA_W'(cols);
    @(posedge clk_i);
    cfg_index_i <= CFG_CANVAS_HEIGHT;
    cfg_data_i  <= CFG_DATA_W'(rows);
    @(posedge clk_i);
    cfg_index_i <= CFG_BACKGROUND_CHAR;
    cfg_data_i  <= CFG_DATA_W'(bg);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg  = DIM_W'(cols);
    height_reg = DIM_W'(rows);
    bg_reg     = bg;
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                 input logic [CHAR_W-1:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pixel_answers.size() == 0) begin
        report_mismatch("result with no request outstanding", rsp_ch.item.pixel_char, 'x);
      end else begin
        want = pixel_answers.pop_front();
        if (rsp_ch.item.pixel_char !== want.pixel_char)
          report_mismatch("pixel_char", rsp_ch.item.pixel_char, want.pixel_char);
        if (rsp_ch.item.rejected !== want.rejected)
          report_mismatch("rejected", CHAR_W'(rsp_ch.item.rejected), CHAR_W'(want.rejected));
      end
    end
  end

  initial begin : response_sink
    int unsigned stall_left;
    logic take;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      rsp_ch.ready <= take;
    end
  end

  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic test_directed();
    configure(8, 6, ".");
    send_request(clear_item());
    send_request(read_item(0, 0));
    send_request(draw_item(1 * UNIT, 1 * UNIT, 5 * UNIT, 3 * UNIT, SHAPE_OUTLINE, "#"));
    send_request(read_item(1, 1));
    send_request(read_item(3, 2));
    send_request(read_item(6, 4));
    send_request(draw_item(2 * UNIT + UNIT / 2, UNIT * 3 / 4, 3 * UNIT + UNIT / 4, 2 * UNIT,
                           SHAPE_FILLED, "o"));
    send_request(read_item(3, 2));
    // A zero-sized rectangle still paints the single pixel it sits on.
    send_request(draw_item(7 * UNIT, 5 * UNIT, 0, 0, SHAPE_FILLED, "x"));
    send_request(read_item(7, 5));
    send_request(draw_item(0, 0, -1, 2 * UNIT, SHAPE_FILLED, "!"));
    send_request(draw_item(0, 0, 2 * UNIT, -524288, SHAPE_OUTLINE, "!"));
    send_request(draw_item(0, 0, 2 * UNIT, 2 * UNIT, BAD_SHAPE, "!"));
    send_request(draw_item(0, 0, 2 * UNIT, 2 * UNIT, 8'hff, "!"));
    send_request(noise_item());
    send_request(read_item(8, 0));
    send_request(read_item(0, 6));
    send_request(read_item(255, 255));
    send_request(draw_item(-524288, -524288, 524287, 524287, SHAPE_FILLED, "?"));
    send_request(draw_item(524287, 524287, 524287, 524287, SHAPE_OUTLINE, "?"));
    send_request(draw_item(-UNIT, -UNIT / 2, 524287, 524287, SHAPE_FILLED, "*"));
    send_request(read_item(0, 0));
    send_request(read_item(7, 5));
    send_request(draw_item(UNIT / 2, 0, 5 * UNIT, 4 * UNIT, SHAPE_OUTLINE, "+"));
    send_request(read_item(5, 4));
    wait_for_results();
  endtask

  task automatic test_size_limits();
    // A size of zero acts as one pixel.
    configure(0, 0, 8'h00);
    send_request(clear_item());
    send_request(read_item(0, 0));
    send_request(draw_item(0, 0, 0, 0, SHAPE_FILLED, 8'hff));
    send_request(read_item(0, 0));
    send_request(read_item(1, 0));
    send_request(read_item(0, 1));
    wait_for_results();
    // Anything above the largest side acts as the largest side.
    configure(257, 3, 8'h5a);
    send_request(clear_item());
    send_request(draw_item(250 * UNIT + UNIT / 2, -UNIT / 2, 10 * UNIT, 2 * UNIT + UNIT / 4,
                           SHAPE_OUTLINE, "E"));
    send_request(read_item(255, 0));
    send_request(read_item(255, 2));
    send_request(read_item(254, 1));
    send_request(read_item(0, 3));
    wait_for_results();
    configure(1, 256, "|");
    send_request(clear_item());
    send_request(draw_item(0, 100 * UNIT, 0, 155 * UNIT + 1, SHAPE_OUTLINE, "v"));
    send_request(read_item(0, 255));
    send_request(read_item(0, 99));
    send_request(read_item(0, 200));
    send_request(read_item(1, 0));
    wait_for_results();
  endtask

  task automatic test_full_canvas();
    configure(511, 256, 8'hff);
    send_request(clear_item());
    send_request(draw_item(100 * UNIT + UNIT / 4, -3 * UNIT, 155 * UNIT + UNIT * 3 / 4,
                           60 * UNIT, SHAPE_FILLED, "F"));
    send_request(draw_item(0, 0, 255 * UNIT, 255 * UNIT, SHAPE_OUTLINE, "@"));
    send_request(read_item(0, 0));
    send_request(read_item(255, 255));
    send_request(read_item(128, 128));
    send_request(read_item(255, 0));
    send_request(read_item(130, 10));
    send_request(read_item(101, 30));
    send_request(read_item(254, 254));
    wait_for_results();
  endtask

  task automatic test_backpressure();
    configure(12, 10, "-");
    send_request(clear_item());
    wait_for_results();
    // The output side holds off while requests keep coming, so the input must stall.
    hold_off_cycles = 300;
    for (int n = 0; n < 20; n++) begin
      if (n % 5 == 2) send_request(random_draw(12, 10));
      else send_request(random_read(12, 10));
    end
    wait_for_results();
  endtask

  task automatic test_random();
    int unsigned cols, rows, pick;
    req_t item;
    for (int phase = 0; phase < 4; phase++) begin
      idle_en = (phase != 3);
      configure($urandom_range(0, 24), $urandom_range(0, 24), CHAR_W'($urandom));
      cols = side_in_use(width_reg);
      rows = side_in_use(height_reg);
      // Later phases may keep the old picture, grown or cut down.
      if (phase == 0 || $urandom_range(0, 1) == 1) send_request(clear_item());
      for (int n = 0; n < 8; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          item = random_draw(cols, rows);
        end else if (pick < 50) begin
          item = noise_item();
          item.kind = KIND_DRAW;
          if ($urandom_range(0, 9) < 7)
            item.shape_char = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
        end else if (pick < 85) begin
          item = random_read(cols, rows);
        end else if (pick < 93) begin
          item = clear_item();
        end else begin
          item = noise_item();
        end
        send_request(item);
      end
      wait_for_results();
    end
  endtask

  initial begin : run_tests
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_CANVAS_WIDTH;
    cfg_data_i   <= '0;
    req_ch.valid <= 1'b0;
    req_ch.item  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_size_limits();
    test_full_canvas();
    test_backpressure();
    test_random();

    idle_en = 1'b0;
    wait_for_results();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pixel_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
